// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the threshold block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define OHT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checked on every edge, reset included.
`define OHT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// ===== rtl/core/oht_pkg.sv =====
// ----------------------------------------------------------------------------
// oht_pkg
// Types, widths and codes shared by the Otsu threshold block.
// ----------------------------------------------------------------------------
package oht_pkg;

  localparam int DEF_FRAME_WIDTH  = 188;
  localparam int DEF_FRAME_HEIGHT = 120;
  localparam int DEF_GRAY_LEVELS  = 256;

  localparam int COUNT_W = 15;
  localparam int SUM_W   = 23;
  localparam int D_W     = COUNT_W + SUM_W;
  localparam int DEN_W   = 2 * COUNT_W;
  localparam int DD_W    = 2 * D_W;
  localparam int P_W     = DD_W + D_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_END   = 2'd2;

  localparam logic [7:0] COL_END_RESET = 8'd188;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_READ,
    ST_ACC,
    ST_PROD,
    ST_DIFF,
    ST_MUL_DD,
    ST_PICK,
    ST_MUL_P1,
    ST_MUL_P2,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_write;
    logic idx_inc;
    logic pix_capture;
    logic pix_update;
    logic scan_read;
    logic scan_acc;
    logic scan_prod;
    logic mul_start_dd;
    logic dd_load;
    logic mul_start_p1;
    logic p1_load;
    logic mul_start_p2;
    logic take_best;
    logic out_load;
    logic frame_clear;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic pix_last;
    logic skip_level;
    logic mul_done;
    logic better;
    logic found;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/oht_serial_mul.sv =====
// ----------------------------------------------------------------------------
// oht_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle, early finish.
// ----------------------------------------------------------------------------
module oht_serial_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [oht_pkg::DD_W-1:0]  mcand,
  input  logic [oht_pkg::D_W-1:0]   mplier,
  output logic                      done,
  output logic [oht_pkg::P_W-1:0]   prod
);
  import oht_pkg::*;

  logic            busy;
  logic [P_W-1:0]  acc;
  logic [P_W-1:0]  mc;
  logic [D_W-1:0]  mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && mp == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mc  <= P_W'(mcand);
      mp  <= mplier;
    end else if (busy && mp != '0) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

  assign done = busy && (mp == '0);
  assign prod = acc;

endmodule

// ===== rtl/core/oht_datapath.sv =====
// ----------------------------------------------------------------------------
// oht_datapath
// Histogram memory, window counters, frame totals and variance compare.
// ----------------------------------------------------------------------------
module oht_datapath #(
  parameter int FRAME_WIDTH  = oht_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = oht_pkg::DEF_FRAME_HEIGHT,
  parameter int GRAY_LEVELS  = oht_pkg::DEF_GRAY_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  oht_pkg::cmd_t                   cmd,
  output oht_pkg::status_t                sts,
  input  logic                            cfg_valid,
  input  logic [oht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [oht_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                      gray_pixel,
  input  logic                            frame_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      best_threshold,
  output logic                            found_split
);
  import oht_pkg::*;

  localparam int LW = $clog2(GRAY_LEVELS);
  localparam int CW = $clog2(FRAME_WIDTH);
  localparam int RW = $clog2(FRAME_HEIGHT);

  logic [COUNT_W-1:0] mem [GRAY_LEVELS];
  logic [COUNT_W-1:0] rd;
  logic [LW-1:0]      rd_addr;
  logic [LW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic               wr_en;

  logic [6:0]   win_row_start;
  logic [7:0]   win_col_start;
  logic [7:0]   win_col_end;

  logic [RW-1:0]      row_pos;
  logic [CW-1:0]      col_pos;
  logic [SUM_W-1:0]   gray_total;
  logic [COUNT_W-1:0] counted;

  logic [LW-1:0]  pix_level;
  logic [LW-1:0]  in_level;
  logic           pix_last;
  logic           pix_count;
  logic           in_window;

  logic [LW-1:0]      idx;
  logic               idx_last;
  logic [COUNT_W-1:0] c0;
  logic [SUM_W-1:0]   s0;
  logic [D_W-1:0]     a_val;
  logic [D_W-1:0]     b_val;
  logic [DEN_W-1:0]   den;
  logic               skip_class;
  logic [D_W-1:0]     diff;
  logic [DD_W-1:0]    dd;
  logic [P_W-1:0]     p1;

  logic               found;
  logic [LW-1:0]      best_level;
  logic [DD_W-1:0]    best_dd;
  logic [DEN_W-1:0]   best_den;

  logic               mul_start;
  logic [DD_W-1:0]    mul_mcand;
  logic [D_W-1:0]     mul_mplier;
  logic               mul_done;
  logic [P_W-1:0]     mul_prod;

  assign in_level = (gray_pixel > 8'(GRAY_LEVELS - 1)) ? LW'(GRAY_LEVELS - 1)
                                                       : gray_pixel[LW-1:0];
  assign in_window = (32'(row_pos) >= 32'(win_row_start)) &&
                     (32'(col_pos) >= 32'(win_col_start)) &&
                     (32'(col_pos) <  32'(win_col_end)) &&
                     (counted < COUNT_MAX);
  assign idx_last = (idx == LW'(GRAY_LEVELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      win_row_start <= '0;
      win_col_start <= '0;
      win_col_end   <= COL_END_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_START: win_row_start <= cfg_data[6:0];
        REG_COL_START: win_col_start <= cfg_data;
        REG_COL_END:   win_col_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Histogram memory: one write, one registered read per cycle.
  assign rd_addr = cmd.pix_capture ? in_level : idx;
  assign wr_addr = cmd.pix_update ? pix_level : idx;
  assign wr_data = cmd.pix_update ? rd + 1'b1 : '0;
  assign wr_en   = (cmd.pix_update && pix_count) || cmd.clr_write;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.pix_capture || cmd.scan_read) begin
      rd <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_capture) begin
      pix_level <= in_level;
      pix_last  <= frame_last;
      pix_count <= in_window;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      row_pos    <= '0;
      col_pos    <= '0;
      gray_total <= '0;
      counted    <= '0;
    end else if (cmd.pix_update) begin
      if (pix_count) begin
        gray_total <= gray_total + SUM_W'(pix_level);
        counted    <= counted + 1'b1;
      end
      if (!pix_last) begin
        if (col_pos == CW'(FRAME_WIDTH - 1)) begin
          col_pos <= '0;
          row_pos <= (row_pos == RW'(FRAME_HEIGHT - 1)) ? '0 : row_pos + 1'b1;
        end else begin
          col_pos <= col_pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      c0    <= '0;
      s0    <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.scan_acc) begin
        c0 <= c0 + rd;
        s0 <= s0 + SUM_W'(idx) * SUM_W'(rd);
      end
      if (cmd.take_best) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_prod) begin
      a_val      <= D_W'(gray_total) * D_W'(c0);
      b_val      <= D_W'(counted) * D_W'(s0);
      den        <= DEN_W'(c0) * DEN_W'(counted - c0);
      skip_class <= (c0 == '0) || (c0 >= counted);
    end
    if (cmd.dd_load) begin
      dd <= mul_prod[DD_W-1:0];
    end
    if (cmd.p1_load) begin
      p1 <= mul_prod;
    end
    if (cmd.take_best) begin
      best_level <= idx;
      best_dd    <= dd;
      best_den   <= den;
    end
  end

  assign diff = (a_val > b_val) ? a_val - b_val : b_val - a_val;

  assign mul_start = cmd.mul_start_dd || cmd.mul_start_p1 || cmd.mul_start_p2;
  always_comb begin
    mul_mcand  = DD_W'(diff);
    mul_mplier = diff;
    if (cmd.mul_start_p1) begin
      mul_mcand  = dd;
      mul_mplier = D_W'(best_den);
    end else if (cmd.mul_start_p2) begin
      mul_mcand  = best_dd;
      mul_mplier = D_W'(den);
    end
  end

  oht_serial_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      best_threshold <= found ? 8'(best_level) : 8'd0;
      found_split    <= found;
    end
  end

  assign sts.idx_last   = idx_last;
  assign sts.pix_last   = pix_last;
  assign sts.skip_level = skip_class || (a_val == b_val);
  assign sts.mul_done   = mul_done;
  assign sts.better     = p1 > mul_prod;
  assign sts.found      = found;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/core/oht_ctrl.sv =====
// ----------------------------------------------------------------------------
// oht_ctrl
// Sequencer for pixel update, histogram clear and threshold scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  oht_pkg::status_t    sts,
  output oht_pkg::cmd_t       cmd
);
  import oht_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (sts.idx_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.pix_capture = 1'b1;
          state_next      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.pix_update = 1'b1;
        state_next     = sts.pix_last ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        cmd.scan_read = 1'b1;
        cmd.clr_write = 1'b1;
        state_next    = ST_ACC;
      end
      ST_ACC: begin
        cmd.scan_acc = 1'b1;
        state_next   = ST_PROD;
      end
      ST_PROD: begin
        cmd.scan_prod = 1'b1;
        state_next    = ST_DIFF;
      end
      ST_DIFF: begin
        if (sts.skip_level) begin
          state_next = ST_NEXT;
        end else begin
          cmd.mul_start_dd = 1'b1;
          state_next       = ST_MUL_DD;
        end
      end
      ST_MUL_DD: begin
        if (sts.mul_done) begin
          cmd.dd_load = 1'b1;
          state_next  = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!sts.found) begin
          cmd.take_best = 1'b1;
          state_next    = ST_NEXT;
        end else begin
          cmd.mul_start_p1 = 1'b1;
          state_next       = ST_MUL_P1;
        end
      end
      ST_MUL_P1: begin
        if (sts.mul_done) begin
          cmd.p1_load      = 1'b1;
          cmd.mul_start_p2 = 1'b1;
          state_next       = ST_MUL_P2;
        end
      end
      ST_MUL_P2: begin
        if (sts.mul_done) begin
          cmd.take_best = sts.better;
          state_next    = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd.idx_inc = 1'b1;
        state_next  = sts.idx_last ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.frame_clear = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  `OHT_ASSERT(a_out_slot_free, cmd.out_load |-> sts.out_free, "result loaded over a pending one")
  `OHT_ASSERT(a_update_follows, cmd.pix_capture |=> cmd.pix_update, "pixel update skipped")
  `OHT_ASSERT(a_take_needs_win, (cmd.take_best && sts.found) |-> sts.better, "non-improving level taken")
  `OHT_ASSERT(a_one_mul_start, $onehot0({cmd.mul_start_dd, cmd.mul_start_p1, cmd.mul_start_p2}), "two multiplies started")

endmodule

// ===== rtl/core/otsu_histogram_threshold.sv =====
// ----------------------------------------------------------------------------
// otsu_histogram_threshold
// Windowed gray histogram per frame and Otsu threshold search at frame end.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata = gray_pixel, tlast = frame_last
// m_axis    out  tvalid/tready          tdata = best_threshold, tuser = found_split
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A pixel is a histogram read, then an increment write; no pixel is taken
// in between. After the last pixel of a frame the scan visits each level
// through read, accumulate, product and difference states and, unless the
// level is skipped, one to three shift-add multiplies, which dominate the scan.
// After reset a clearing pass zeroes every level before pixels are taken.
// A stalled result holds in the output register; only the frame end waits on it.
// ----------------------------------------------------------------------------
module otsu_histogram_threshold #(
  parameter int FRAME_WIDTH  = oht_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = oht_pkg::DEF_FRAME_HEIGHT,
  parameter int GRAY_LEVELS  = oht_pkg::DEF_GRAY_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] gray_pixel
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] best_threshold
  output logic                            m_axis_tuser,   // [0] found_split
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [oht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [oht_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import oht_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  oht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oht_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .GRAY_LEVELS  (GRAY_LEVELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .gray_pixel     (s_axis_tdata),
    .frame_last     (s_axis_tlast),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .best_threshold (m_axis_tdata),
    .found_split    (m_axis_tuser)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives short gray frames through the Otsu threshold block under a set of
// window settings, predicts each frame's threshold with an exact integer scan
// and checks every result item against it, with random input gaps and
// output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import oht_pkg::*;

  localparam int WDOG_LIMIT = 300000;
  localparam int FR_W = 188;
  localparam int FR_H = 120;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] gray;
    logic       last;
  } pixel_t;

  typedef struct {
    logic [7:0] level;
    logic       split;
  } thresh_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [7:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  otsu_histogram_threshold uut (.*);

  pixel_t  pixel_q[$];
  thresh_t thresh_q[$];
  int      errors;
  int      items_made;
  bit      pix_taken;
  int      burst_left, gap_left, stall_left, run_left;
  int      idle_cycles;

  // predictor copy of block state
  int unsigned hist[256];
  int unsigned sum_g, cnt, row_pos, col_pos;
  int unsigned win_row, win_col0, win_col1;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic thresh_t search_level();
    thresh_t r;
    logic [127:0] n, s, c0, s0, a, b, d, den, bd, bden, lhs, rhs;
    r.level = 0;
    r.split = 0;
    n = 128'(cnt);
    s = 128'(sum_g);
    c0 = 0;
    s0 = 0;
    bd = 0;
    bden = 1;
    for (int j = 0; j < 256; j++) begin
      c0 += 128'(hist[j]);
      s0 += 128'(j) * 128'(hist[j]);
      if (c0 == 0 || c0 >= n) continue;
      a = s * c0;
      b = n * s0;
      d = (a > b) ? a - b : b - a;
      if (d == 0) continue;
      den = c0 * (n - c0);
      lhs = d * d * bden;
      rhs = bd * bd * den;
      if (!r.split || lhs > rhs) begin
        r.split = 1;
        bd = d;
        bden = den;
        r.level = 8'(j);
      end
    end
    return r;
  endfunction

  task automatic take_pixel(logic [7:0] g, logic last);
    if (row_pos >= win_row && col_pos >= win_col0 && col_pos < win_col1 &&
        cnt < 32767) begin
      hist[g]++;
      sum_g += 32'(g);
      cnt++;
    end
    if (!last) begin
      col_pos++;
      if (col_pos >= FR_W) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= FR_H) row_pos = 0;
      end
    end else begin
      thresh_q.push_back(search_level());
      foreach (hist[i]) hist[i] = 0;
      sum_g = 0;
      cnt = 0;
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else if (!s_axis_tvalid || pix_taken) begin
      pix_taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 0;
      end else if (pixel_q.size() > 0) begin
        s_axis_tdata  <= pixel_q[0].gray;
        s_axis_tlast  <= pixel_q[0].last;
        s_axis_tvalid <= 1;
        void'(pixel_q.pop_front());
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 0;
    end else if (run_left > 0) begin
      run_left--;
      m_axis_tready <= 1;
    end else begin
      stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      run_left = $urandom_range(0, 10);
      m_axis_tready <= (stall_left == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pix_taken = 1;
        take_pixel(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (thresh_q.size() == 0) begin
          report("unexpected result", m_axis_tdata, -1);
        end else begin
          if (m_axis_tdata !== thresh_q[0].level)
            report("best_threshold", m_axis_tdata, thresh_q[0].level);
          if (m_axis_tuser !== thresh_q[0].split)
            report("found_split", m_axis_tuser, thresh_q[0].split);
          void'(thresh_q.pop_front());
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROW_START: win_row = 32'(val & 8'h7f);
      REG_COL_START: win_col0 = 32'(val);
      REG_COL_END:   win_col1 = 32'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    wait (pixel_q.size() == 0 && !s_axis_tvalid && thresh_q.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_window(int r, int c0, int c1);
    drain();
    write_reg(REG_ROW_START, 8'(r));
    write_reg(REG_COL_START, 8'(c0));
    write_reg(REG_COL_END, 8'(c1));
  endtask

  task automatic make_frame(int len, int kind);
    pixel_t p;
    logic [7:0] lo, hi;
    lo = 8'($urandom);
    hi = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: p.gray = 8'($urandom);
        1: p.gray = $urandom_range(0, 1) ? lo : hi;
        2: p.gray = lo;
        3: p.gray = $urandom_range(0, 1) ? 8'd0 : 8'd255;
        default: p.gray = $urandom_range(0, 1) ? 8'(lo + $urandom_range(0, 3))
                                                  : 8'(hi - $urandom_range(0, 3));
      endcase
      p.last = (i == len - 1);
      pixel_q.push_back(p);
    end
    items_made += len;
  endtask

  task automatic push_px(logic [7:0] g, logic last);
    pixel_t p;
    p.gray = g;
    p.last = last;
    pixel_q.push_back(p);
    items_made++;
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tlast = 0;
    m_axis_tready = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    errors = 0;
    items_made = 0;
    pix_taken = 0;
    burst_left = 0;
    gap_left = 0;
    stall_left = 0;
    run_left = 0;
    idle_cycles = 0;
    foreach (hist[i]) hist[i] = 0;
    sum_g = 0;
    cnt = 0;
    row_pos = 0;
    col_pos = 0;
    win_row = 0;
    win_col0 = 0;
    win_col1 = 32'(COL_END_RESET);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // single pixel, constant frame, extremes, tie
    push_px(8'd0, 1);
    push_px(8'd255, 0); push_px(8'd255, 1);
    push_px(8'd0, 0); push_px(8'd255, 1);
    push_px(8'd0, 0); push_px(8'd0, 0); push_px(8'd255, 0); push_px(8'd255, 1);
    push_px(8'd10, 0); push_px(8'd20, 0); push_px(8'd30, 1);
    push_px(8'd85, 0); push_px(8'd170, 0); push_px(8'd1, 0); push_px(8'd254, 1);
    // unused register index, bit 7 of row start masked
    set_window(0, 0, 188);
    write_reg(REG_UNUSED, 8'hff);
    write_reg(REG_ROW_START, 8'h80);
    make_frame(20, 0);
    // column wrap across rows under a narrow window
    set_window(1, 47, 141);
    make_frame(400, 0);
    set_window(119, 187, 188);
    make_frame(30, 0);
    set_window(0, 100, 50);
    make_frame(30, 0);
    set_window(0, 0, 255);
    make_frame(30, 3);
    set_window(0, 187, 188);
    make_frame(200, 1);

    while (items_made < 1350) begin
      case ($urandom_range(0, 5))
        0: set_window(0, 0, 188);
        1: set_window(0, 47, 141);
        2: set_window(0, $urandom_range(0, 20), $urandom_range(1, 40));
        3: set_window($urandom_range(0, 1), $urandom, $urandom);
        default: set_window(0, 0, $urandom_range(1, 188));
      endcase
      repeat (4) make_frame($urandom_range(20, 40), $urandom_range(0, 4));
    end

    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== otsu_histogram_threshold.f =====
+incdir+rtl/core
rtl/core/oht_pkg.sv
rtl/core/oht_serial_mul.sv
rtl/core/oht_datapath.sv
rtl/core/oht_ctrl.sv
rtl/core/otsu_histogram_threshold.sv
dv/tb_top.sv
